FILE: rtl/rcbf_pkg.sv
// constants, types and arithmetic helpers for the rgb555 colour bleed filter
// standalone package, no dependencies
package rcbf_pkg;

	localparam int PIX_W  = 15;
	localparam int CH_W   = 5;
	localparam int JIT_W  = 5;
	localparam int WGT_W  = 11;
	localparam int SUM_W  = 17;
	localparam int RB_SUM_W = 15;
	localparam int QUO_W  = 6;
	localparam int POS_W  = 2;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [CH_W-1:0]  chan_t;
	typedef logic [JIT_W-1:0] jit_t;
	typedef logic [WGT_W-1:0] wgt_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [QUO_W-1:0] quo_t;
	typedef logic [POS_W-1:0] pos_t;

	// channel bit positions inside a pixel
	localparam int RED_LSB   = 10;
	localparam int GREEN_LSB = 5;
	localparam int BLUE_LSB  = 0;

	localparam chan_t CH_MAX = 5'h1F;

	// pixels of a row that pass straight through
	localparam pos_t PASS_COUNT = 2'd3;

	// base weights in thousandths (red, blue) and in 1/3000 (green)
	localparam wgt_t RB_W_CUR = 11'd50;
	localparam wgt_t RB_W_P3  = 11'd100;
	localparam wgt_t RB_W_P2  = 11'd200;
	localparam wgt_t RB_W_P1  = 11'd570;
	localparam wgt_t G_W_CUR  = 11'd90;
	localparam wgt_t G_W_P3   = 11'd300;
	localparam wgt_t G_W_P2   = 11'd600;
	localparam wgt_t G_W_P1   = 11'd1890;

	// reciprocals for the divides by 1000 and 3000, exact over the sum ranges
	localparam int RB_RECIP_W = 16;
	localparam int RB_SHIFT   = 25;
	localparam logic [RB_RECIP_W-1:0] RB_RECIP = 16'd33555;
	localparam int G_RECIP_W  = 18;
	localparam int G_SHIFT    = 29;
	localparam logic [G_RECIP_W-1:0] G_RECIP = 18'd178957;

	function automatic chan_t chan_of(pix_t p, int lsb);
		return p[lsb +: CH_W];
	endfunction

	function automatic wgt_t add_jit(wgt_t base, jit_t j);
		return base + wgt_t'(j);
	endfunction

	// weighted sum of current pixel and the three before it
	function automatic sum_t mix_sum(chan_t c, chan_t p1, chan_t p2, chan_t p3,
			wgt_t wc, wgt_t wp1, wgt_t wp2, wgt_t wp3);
		sum_t acc;
		acc = sum_t'(c) * sum_t'(wc) + sum_t'(p1) * sum_t'(wp1)
			+ sum_t'(p2) * sum_t'(wp2) + sum_t'(p3) * sum_t'(wp3);
		return acc;
	endfunction

	function automatic chan_t sat_chan(quo_t q);
		return (q > quo_t'(CH_MAX)) ? CH_MAX : q[CH_W-1:0];
	endfunction

endpackage

FILE: rtl/rgb555_color_bleed_filter.sv
// rgb555 leftward colour bleed filter, top level
// uses rcbf_pkg for widths, weights and the mixing helpers
// ---------------------------------------------------------------------------
// Takes one RGB555 pixel per clock and gives one filtered pixel per clock,
// in order, while result_stall is low. A pixel that is taken passes through
// the input register, the weighted-sum register and the output register.
// Throughput is one pixel per cycle without stalls; while a finished pixel
// waits in the output register, earlier stages still fill up. Assert
// row_start with the first pixel of each row, together with the four jitter
// values for that row; the first three pixels of a row come out unchanged
// and every later pixel mixes in the three original pixels before it. Until
// the first row_start the stream is treated as a row with zero jitter.
// Channel results above 31 clamp to 31. No clearing pass after reset.
// ---------------------------------------------------------------------------
module rgb555_color_bleed_filter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      feed_valid,
	output logic                      feed_stall,
	input  rcbf_pkg::pix_t            pixel_in,
	input  logic                      row_start,
	input  rcbf_pkg::jit_t            jitter_a,
	input  rcbf_pkg::jit_t            jitter_b,
	input  rcbf_pkg::jit_t            jitter_c,
	input  rcbf_pkg::jit_t            jitter_d,
	output logic                      result_valid,
	input  logic                      result_stall,
	output rcbf_pkg::pix_t            pixel_out
);

	// row state
	rcbf_pkg::pix_t prior1_q, prior2_q, prior3_q;
	rcbf_pkg::pos_t pos_q;
	rcbf_pkg::jit_t jit0_q, jit1_q, jit2_q, jit3_q;

	// stage 1: captured word
	logic           v_s1;
	logic           pass_s1;
	rcbf_pkg::pix_t pix_s1, p1_s1, p2_s1, p3_s1;
	rcbf_pkg::jit_t j0_s1, j1_s1, j2_s1, j3_s1;

	// stage 2: weighted sums
	logic           v_s2;
	logic           pass_s2;
	rcbf_pkg::pix_t pix_s2;
	logic [rcbf_pkg::RB_SUM_W-1:0] sum_r_s2, sum_b_s2;
	rcbf_pkg::sum_t sum_g_s2;

	rcbf_pkg::pix_t pixel_q;
	logic           out_valid_q;

	logic adv_out, adv_s2, adv_s1, accept;
	rcbf_pkg::pos_t pos_eff;
	logic           pass_now;

	rcbf_pkg::sum_t mix_r, mix_g, mix_b;
	logic [rcbf_pkg::RB_SUM_W+rcbf_pkg::RB_RECIP_W-1:0] prod_r, prod_b;
	logic [rcbf_pkg::SUM_W+rcbf_pkg::G_RECIP_W-1:0]     prod_g;
	rcbf_pkg::chan_t res_r, res_g, res_b;

	// each stage loads when it is empty or its word moves on
	assign adv_out    = !out_valid_q || !result_stall;
	assign adv_s2     = !v_s2 || adv_out;
	assign adv_s1     = !v_s1 || adv_s2;
	assign feed_stall = !adv_s1;
	assign accept     = feed_valid && adv_s1;

	assign pos_eff  = row_start ? '0 : pos_q;
	assign pass_now = pos_eff < rcbf_pkg::PASS_COUNT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior1_q <= '0;
			prior2_q <= '0;
			prior3_q <= '0;
			pos_q    <= '0;
			jit0_q   <= '0;
			jit1_q   <= '0;
			jit2_q   <= '0;
			jit3_q   <= '0;
		end else if (accept) begin
			prior1_q <= pixel_in;
			prior2_q <= prior1_q;
			prior3_q <= prior2_q;
			pos_q    <= pass_now ? pos_eff + rcbf_pkg::pos_t'(1) : rcbf_pkg::PASS_COUNT;
			if (row_start) begin
				jit0_q <= jitter_a;
				jit1_q <= jitter_b;
				jit2_q <= jitter_c;
				jit3_q <= jitter_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= feed_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_out) begin
				out_valid_q <= v_s2;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pixel_in;
			p1_s1   <= prior1_q;
			p2_s1   <= prior2_q;
			p3_s1   <= prior3_q;
			pass_s1 <= pass_now;
			j0_s1   <= row_start ? jitter_a : jit0_q;
			j1_s1   <= row_start ? jitter_b : jit1_q;
			j2_s1   <= row_start ? jitter_c : jit2_q;
			j3_s1   <= row_start ? jitter_d : jit3_q;
		end
	end

	always_comb begin
		mix_r = rcbf_pkg::mix_sum(
			rcbf_pkg::chan_of(pix_s1, rcbf_pkg::RED_LSB),
			rcbf_pkg::chan_of(p1_s1, rcbf_pkg::RED_LSB),
			rcbf_pkg::chan_of(p2_s1, rcbf_pkg::RED_LSB),
			rcbf_pkg::chan_of(p3_s1, rcbf_pkg::RED_LSB),
			rcbf_pkg::add_jit(rcbf_pkg::RB_W_CUR, j0_s1),
			rcbf_pkg::add_jit(rcbf_pkg::RB_W_P1, j3_s1),
			rcbf_pkg::add_jit(rcbf_pkg::RB_W_P2, j2_s1),
			rcbf_pkg::add_jit(rcbf_pkg::RB_W_P3, j1_s1));
		mix_g = rcbf_pkg::mix_sum(
			rcbf_pkg::chan_of(pix_s1, rcbf_pkg::GREEN_LSB),
			rcbf_pkg::chan_of(p1_s1, rcbf_pkg::GREEN_LSB),
			rcbf_pkg::chan_of(p2_s1, rcbf_pkg::GREEN_LSB),
			rcbf_pkg::chan_of(p3_s1, rcbf_pkg::GREEN_LSB),
			rcbf_pkg::add_jit(rcbf_pkg::G_W_CUR, j2_s1),
			rcbf_pkg::add_jit(rcbf_pkg::G_W_P1, j1_s1),
			rcbf_pkg::add_jit(rcbf_pkg::G_W_P2, j3_s1),
			rcbf_pkg::add_jit(rcbf_pkg::G_W_P3, j0_s1));
		mix_b = rcbf_pkg::mix_sum(
			rcbf_pkg::chan_of(pix_s1, rcbf_pkg::BLUE_LSB),
			rcbf_pkg::chan_of(p1_s1, rcbf_pkg::BLUE_LSB),
			rcbf_pkg::chan_of(p2_s1, rcbf_pkg::BLUE_LSB),
			rcbf_pkg::chan_of(p3_s1, rcbf_pkg::BLUE_LSB),
			rcbf_pkg::add_jit(rcbf_pkg::RB_W_CUR, j3_s1),
			rcbf_pkg::add_jit(rcbf_pkg::RB_W_P1, j0_s1),
			rcbf_pkg::add_jit(rcbf_pkg::RB_W_P2, j1_s1),
			rcbf_pkg::add_jit(rcbf_pkg::RB_W_P3, j2_s1));
	end

	// stage 2 payload; red and blue sums stay below 2^15
	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			pix_s2   <= pix_s1;
			pass_s2  <= pass_s1;
			sum_r_s2 <= mix_r[rcbf_pkg::RB_SUM_W-1:0];
			sum_g_s2 <= mix_g;
			sum_b_s2 <= mix_b[rcbf_pkg::RB_SUM_W-1:0];
		end
	end

	// divide by 1000 / 3000 through reciprocal multiply, then clamp
	always_comb begin
		prod_r = sum_r_s2 * rcbf_pkg::RB_RECIP;
		prod_b = sum_b_s2 * rcbf_pkg::RB_RECIP;
		prod_g = sum_g_s2 * rcbf_pkg::G_RECIP;
		res_r  = rcbf_pkg::sat_chan(prod_r[rcbf_pkg::RB_SHIFT +: rcbf_pkg::QUO_W]);
		res_g  = rcbf_pkg::sat_chan(prod_g[rcbf_pkg::G_SHIFT +: rcbf_pkg::QUO_W]);
		res_b  = rcbf_pkg::sat_chan(prod_b[rcbf_pkg::RB_SHIFT +: rcbf_pkg::QUO_W]);
	end

	always_ff @(posedge clk) begin
		if (adv_out && v_s2) begin
			pixel_q <= pass_s2 ? pix_s2 : {res_r, res_g, res_b};
		end
	end

	assign result_valid = out_valid_q;
	assign pixel_out    = pixel_q;

endmodule
